/* design/der_tlv_header_parser_defines.svh */
// assertion macros used by the der tlv header parser back end
`ifndef DER_TLV_HEADER_PARSER_DEFINES_SVH
`define DER_TLV_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define DTHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dthp_pkg.sv */
// shared types, codes and constants of the der tlv header parser
package dthp_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic CFG_EXPECTED_TAG = 1'b0;
    localparam logic CFG_CHECK_TAG    = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TAG      = 3'd1;
    localparam logic [2:0] ST_INDEF    = 3'd2;
    localparam logic [2:0] ST_TOO_MANY = 3'd3;
    localparam logic [2:0] ST_NONCANON = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;
    localparam logic [2:0] ST_EXCEEDS  = 3'd6;

    localparam logic [7:0] LEN_INDEF   = 8'h80;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [31:0] bytes_after;
        logic        start_flag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] content_length;
        logic [2:0]  header_length;
    } out_item_t;

    // classified byte handed from the front end to the parser
    typedef struct packed {
        logic [7:0]  in_byte;
        logic [31:0] bytes_after;
        logic        start_flag;
        logic        tag_mode;    // start byte is a tag byte
        logic        tag_ok;      // byte equals expected tag
        logic        short_over;  // short-form length above bytes_after
        logic        too_many;    // long-form count above the limit
        logic        cnt_over;    // long-form count above bytes_after
    } cls_t;

endpackage

/* design/dthp_fifo.sv */
// small synchronous fifo used as the decoupling queues
module dthp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dthp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    // depth is a power of two so the pointers wrap on their own
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* design/dthp_front.sv */
// front end: configuration registers and per-byte classification
module dthp_front #(
    parameter int MAX_LENGTH_BYTES = dthp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [7:0]        cfg_wdata,
    input  dthp_pkg::in_item_t in_item,
    output dthp_pkg::cls_t    cls_item
);

    logic [7:0] expected_tag_reg, expected_tag_next;
    logic       check_tag_reg, check_tag_next;

    always_comb
    begin
        expected_tag_next = expected_tag_reg;
        check_tag_next    = check_tag_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                dthp_pkg::CFG_EXPECTED_TAG: expected_tag_next = cfg_wdata;
                dthp_pkg::CFG_CHECK_TAG:    check_tag_next    = cfg_wdata[0];
                default:                    check_tag_next    = check_tag_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_tag_reg <= 8'h00;
            check_tag_reg    <= 1'b1;
        end
        else
        begin
            expected_tag_reg <= expected_tag_next;
            check_tag_reg    <= check_tag_next;
        end
    end

    always_comb
    begin
        cls_item.in_byte     = in_item.in_byte;
        cls_item.bytes_after = in_item.bytes_after;
        cls_item.start_flag  = in_item.start_flag;
        cls_item.tag_mode    = in_item.start_flag && check_tag_reg;
        cls_item.tag_ok      = (in_item.in_byte == expected_tag_reg);
        cls_item.short_over  = (32'(in_item.in_byte) > in_item.bytes_after);
        cls_item.too_many    = (in_item.in_byte[6:0] > 7'(MAX_LENGTH_BYTES));
        cls_item.cnt_over    = (32'(in_item.in_byte[6:0]) > in_item.bytes_after);
    end

endmodule

/* design/dthp_back.sv */
// back end: header parse state machine and result generation
`include "der_tlv_header_parser_defines.svh"

module dthp_back #(
    parameter int MAX_LENGTH_BYTES = dthp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dthp_pkg::cls_t      head,
    input  logic                head_empty,
    output logic                head_pop,
    output logic                res_push,
    output dthp_pkg::out_item_t res_item,
    input  logic                res_full
);

    localparam int ACC_W = 8 * MAX_LENGTH_BYTES;
    localparam int CMP_W = (ACC_W > 32) ? ACC_W : 32;
    localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_LEN_FIRST = 2'd1;
    localparam logic [1:0] PH_LEN_MORE  = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [LEFT_W-1:0] total_reg, total_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [2:0]        hcnt_reg, hcnt_next;

    logic              step;
    logic              first_len;
    logic [2:0]        hc;
    logic [ACC_W-1:0]  acc_shift;
    logic [LEFT_W-1:0] left_dec;
    logic [2:0]        st;
    logic [31:0]       len;

    assign step      = !head_empty && !res_full;
    assign head_pop  = step;
    assign first_len = head.start_flag ? !head.tag_mode : (phase_reg == PH_LEN_FIRST);
    assign acc_shift = (acc_reg << 8) | ACC_W'(head.in_byte);
    assign left_dec  = left_reg - LEFT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        total_next = total_reg;
        acc_next   = acc_reg;
        hcnt_next  = hcnt_reg;
        res_push   = 1'b0;
        st         = dthp_pkg::ST_OK;
        len        = '0;
        hc         = (head.start_flag ? 3'd0 : hcnt_reg) + 3'd1;

        if (step)
        begin
            if (head.start_flag && head.tag_mode)
            begin
                hcnt_next = hc;
                if (!head.tag_ok)
                begin
                    res_push = 1'b1;
                    st       = dthp_pkg::ST_TAG;
                end
                else if (head.bytes_after == '0)
                begin
                    res_push = 1'b1;
                    st       = dthp_pkg::ST_TRUNC;
                end
                else
                begin
                    phase_next = PH_LEN_FIRST;
                end
            end
            else if (first_len)
            begin
                hcnt_next = hc;
                if (!head.in_byte[7])
                begin
                    // short form
                    res_push = 1'b1;
                    if (head.short_over)
                    begin
                        st = dthp_pkg::ST_EXCEEDS;
                    end
                    else
                    begin
                        len = 32'(head.in_byte);
                    end
                end
                else if (head.in_byte == dthp_pkg::LEN_INDEF)
                begin
                    res_push = 1'b1;
                    st       = dthp_pkg::ST_INDEF;
                end
                else if (head.too_many)
                begin
                    res_push = 1'b1;
                    st       = dthp_pkg::ST_TOO_MANY;
                end
                else if (head.cnt_over)
                begin
                    res_push = 1'b1;
                    st       = dthp_pkg::ST_TRUNC;
                end
                else
                begin
                    phase_next = PH_LEN_MORE;
                    left_next  = LEFT_W'(head.in_byte[6:0]);
                    total_next = LEFT_W'(head.in_byte[6:0]);
                    acc_next   = '0;
                end
            end
            else if (phase_reg == PH_LEN_MORE)
            begin
                hcnt_next = hc;
                if (left_reg == total_reg && head.in_byte == 8'h00)
                begin
                    // leading zero length byte
                    res_push = 1'b1;
                    st       = dthp_pkg::ST_NONCANON;
                end
                else
                begin
                    acc_next  = acc_shift;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        res_push = 1'b1;
                        if (acc_shift < ACC_W'(128))
                        begin
                            st = dthp_pkg::ST_NONCANON;
                        end
                        else if (CMP_W'(acc_shift) > CMP_W'(head.bytes_after))
                        begin
                            st = dthp_pkg::ST_EXCEEDS;
                        end
                        else
                        begin
                            len = 32'(acc_shift);
                        end
                    end
                    else if (head.bytes_after == '0)
                    begin
                        res_push = 1'b1;
                        st       = dthp_pkg::ST_TRUNC;
                    end
                end
            end

            if (res_push)
            begin
                phase_next = PH_IDLE;
                left_next  = '0;
            end
        end

        res_item.status         = st;
        res_item.content_length = (st == dthp_pkg::ST_OK) ? len : 32'd0;
        res_item.header_length  = hc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            total_reg <= '0;
            acc_reg   <= '0;
            hcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            total_reg <= total_next;
            acc_reg   <= acc_next;
            hcnt_reg  <= hcnt_next;
        end
    end

    `DTHP_ASSERT_NOW(a_more_count_sane, phase_reg == PH_LEN_MORE, left_reg != '0 && left_reg <= total_reg, "length byte count out of range")
    `DTHP_ASSERT_NEXT(a_idle_ignores_stray, step && phase_reg == PH_IDLE && !head.start_flag, phase_reg == PH_IDLE && !$past(res_push), "stray byte changed idle parser")
    `DTHP_ASSERT_NOW(a_result_has_header, res_push, res_item.header_length != 3'd0 || phase_reg == PH_LEN_MORE, "result without header bytes")

endmodule

/* design/der_tlv_header_parser.sv */
// top level of the der tlv header parser
//
// streaming parser for the tag and length of a der tlv header. buffer bytes
// enter on the input queue port (push/full), one transaction per byte, each
// with the count of buffer bytes after it and a start flag. results leave on
// the output queue port (empty/pop): one transaction per header, carrying a
// status, the content length (zero unless ok) and the header length.
// configuration: cfg_we writes cfg_wdata to register cfg_addr (0 expected
// tag, 1 check tag); write it only while the parser is idle.
// the back end parses one byte per cycle while the output queue has room;
// the byte that ends the header passes through the input queue, and the
// parse step then writes its result into the output queue, where the
// receiver can pop it.
// both queues hold two transactions; when the output queue fills, the parse
// step halts, the input queue fills behind it and full rises, so nothing is
// dropped. bytes seen while idle without the start flag give no result.
// reset empties both queues, returns the parser to idle and sets the
// expected tag to zero with tag checking on.
module der_tlv_header_parser #(
    parameter int MAX_LENGTH_BYTES = dthp_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [7:0]          cfg_wdata,
    // byte input
    input  logic                push,
    input  dthp_pkg::in_item_t  in_item,
    output logic                full,
    // result output
    input  logic                pop,
    output dthp_pkg::out_item_t out_item,
    output logic                empty
);

    localparam int CLS_W = $bits(dthp_pkg::cls_t);
    localparam int OUT_W = $bits(dthp_pkg::out_item_t);

    dthp_pkg::cls_t      cls_item;
    dthp_pkg::cls_t      head;
    logic [CLS_W-1:0]    head_bits;
    logic                head_empty;
    logic                head_pop;
    logic                res_push;
    dthp_pkg::out_item_t res_item;
    logic                res_full;
    logic [OUT_W-1:0]    out_bits;

    // classify each byte as it is accepted
    dthp_front #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cls_item  (cls_item)
    );

    // queue between classification and parse
    dthp_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (dthp_pkg::QUEUE_DEPTH)
    ) u_cls_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_item),
        .full  (full),
        .pop   (head_pop),
        .rdata (head_bits),
        .empty (head_empty)
    );

    assign head = dthp_pkg::cls_t'(head_bits);

    // parse state machine, one byte per cycle while the result queue has room
    dthp_back #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .res_push   (res_push),
        .res_item   (res_item),
        .res_full   (res_full)
    );

    // result queue toward the receiver
    dthp_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (dthp_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_bits),
        .empty (empty)
    );

    assign out_item = dthp_pkg::out_item_t'(out_bits);

endmodule
